// ===== rtl/core/pmms_pkg.sv =====
// pmms_pkg: shared types, state and command codes, register indexes and reset
// values for the pick-and-place mission sequencer.
// No dependencies; every other file in rtl/core imports this package.
package pmms_pkg;

    // default width of the wrapping millisecond time base
    localparam int TIME_BITS_DEFAULT = 32;

    // item kinds carried on s_tuser
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_ABORT = 2'd2;
    localparam logic [1:0] MODE_SET   = 2'd3;

    // mission state codes
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_NAVPICK  = 4'd1;
    localparam logic [3:0] S_VERIFY   = 4'd2;
    localparam logic [3:0] S_DOCK     = 4'd3;
    localparam logic [3:0] S_PICK     = 4'd4;
    localparam logic [3:0] S_LIFT     = 4'd5;
    localparam logic [3:0] S_NAVDROP  = 4'd6;
    localparam logic [3:0] S_POSITION = 4'd7;
    localparam logic [3:0] S_RELEASE  = 4'd8;
    localparam logic [3:0] S_RETRACT  = 4'd9;
    localparam logic [3:0] S_YIELD    = 4'd10;
    localparam logic [3:0] S_SAFESTOP = 4'd11;
    localparam logic [3:0] S_ESTOP    = 4'd12;
    localparam logic [3:0] S_COMMLOSS = 4'd13;
    localparam logic [3:0] S_FAULT    = 4'd14;

    // timed sub-steps of pick, lift, release and retract
    localparam logic [1:0] SUB_POSE   = 2'd0;
    localparam logic [1:0] SUB_SETTLE = 2'd1;
    localparam logic [1:0] SUB_GRIP   = 2'd2;

    // arm commands
    localparam logic [3:0] ARM_NONE      = 4'd0;
    localparam logic [3:0] ARM_HOME      = 4'd1;
    localparam logic [3:0] ARM_APPROACH  = 4'd2;
    localparam logic [3:0] ARM_PICK      = 4'd3;
    localparam logic [3:0] ARM_LIFT      = 4'd4;
    localparam logic [3:0] ARM_TRANSPORT = 4'd5;
    localparam logic [3:0] ARM_DROP      = 4'd6;
    localparam logic [3:0] ARM_RETRACT   = 4'd7;
    localparam logic [3:0] ARM_STOP      = 4'd8;

    // arm pose durations in ms
    localparam logic [9:0] MOVE_NONE_MS  = 10'd0;
    localparam logic [9:0] MOVE_SHORT_MS = 10'd600;
    localparam logic [9:0] MOVE_MID_MS   = 10'd700;
    localparam logic [9:0] MOVE_LONG_MS  = 10'd800;

    // gripper, drive and navigation commands
    localparam logic [1:0] GRIP_NONE  = 2'd0;
    localparam logic [1:0] GRIP_CLOSE = 2'd1;
    localparam logic [1:0] GRIP_OPEN  = 2'd2;

    localparam logic [1:0] DRIVE_NONE  = 2'd0;
    localparam logic [1:0] DRIVE_STOP  = 2'd1;
    localparam logic [1:0] DRIVE_CREEP = 2'd2;

    localparam logic [1:0] NAV_NONE = 2'd0;
    localparam logic [1:0] NAV_GOAL = 2'd1;
    localparam logic [1:0] NAV_STOP = 2'd2;
    localparam logic [1:0] NAV_STEP = 2'd3;

    // goal headings in degrees
    localparam logic signed [7:0] HEADING_NONE = 8'sd0;
    localparam logic signed [7:0] HEADING_PICK = 8'sd90;
    localparam logic signed [7:0] HEADING_DROP = -8'sd90;

    // configuration register indexes
    localparam logic [2:0] CFG_PICK_X      = 3'd0;
    localparam logic [2:0] CFG_PICK_Y      = 3'd1;
    localparam logic [2:0] CFG_DROP_X      = 3'd2;
    localparam logic [2:0] CFG_DROP_Y      = 3'd3;
    localparam logic [2:0] CFG_VERIFY_TO   = 3'd4;
    localparam logic [2:0] CFG_POSE_SETTLE = 3'd5;
    localparam logic [2:0] CFG_GRIP_SETTLE = 3'd6;

    // configuration reset values
    localparam logic signed [15:0] PICK_X_RST = 16'sd3500;
    localparam logic signed [15:0] PICK_Y_RST = 16'sd3200;
    localparam logic signed [15:0] DROP_X_RST = 16'sd6000;
    localparam logic signed [15:0] DROP_Y_RST = 16'sd9800;
    localparam logic [15:0] VERIFY_TO_RST     = 16'd1500;
    localparam logic [15:0] POSE_SETTLE_RST   = 16'd800;
    localparam logic [15:0] GRIP_SETTLE_RST   = 16'd600;

    typedef struct packed {
        logic signed [15:0] pick_x;
        logic signed [15:0] pick_y;
        logic signed [15:0] drop_x;
        logic signed [15:0] drop_y;
        logic [15:0]        verify_timeout_ms;
        logic [15:0]        pose_settle_ms;
        logic [15:0]        grip_settle_ms;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] time_ms;
        logic [3:0]  target_state;
        logic        estop;
        logic        yield_req;
        logic        nav_arrived;
        logic        rfid_seen;
        logic        dock_clear;
    } item_t;

    typedef struct packed {
        logic [3:0]         state;
        logic [3:0]         arm_cmd;
        logic [9:0]         arm_move_ms;
        logic [1:0]         gripper_cmd;
        logic [1:0]         drive_cmd;
        logic [1:0]         nav_cmd;
        logic signed [15:0] goal_x;
        logic signed [15:0] goal_y;
        logic signed [7:0]  goal_heading_deg;
    } result_t;

    // sequencer control state other than the time stamp
    typedef struct packed {
        logic [3:0] mission_state;
        logic [3:0] state_before_yield;
        logic [1:0] sub_step;
    } ctrl_t;

endpackage

// ===== rtl/core/pick_place_mission_sequencer.sv =====
// pick_place_mission_sequencer: top level with input and result registers,
// sequencer state and configuration. Depends on pmms_pkg, pmms_cfg_regs, pmms_step.
//
// Usage:
//   s_ channel: one item per handshake; s_tuser is the item kind (tick, start,
//   abort, manual set), s_tdata the time stamp, manual target and status flags.
//   m_ channel: one result item per input item, in order: state plus arm,
//   gripper, drive and navigation commands.
//   cfg_ channel: register writes by index, always ready; write only while the
//   block holds no item in flight.
//   Pipeline: an accepted item is held in the input register, evaluated from
//   it by the sequencer step and its result is held in the result register.
//   Throughput: one item per cycle while m_tready is high; the sequencer step
//   is purely combinational between the input and result registers.
//   Stall: while m_tready is low the result register holds and one more item
//   is taken into the input register; then s_tready drops until the result
//   is taken.
//   Reset: aresetn low clears both valid flags, sets the state to idle with a
//   zero time stamp and loads the configuration reset values.
module pick_place_mission_sequencer #(
    parameter int TIME_BITS = pmms_pkg::TIME_BITS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    // time_ms[31:0], target_state[35:32], estop[36], yield_req[37],
    // nav_arrived[38], rfid_seen[39], dock_clear[40], zero pad[47:41]
    input  logic [47:0] s_tdata,
    // mode[1:0]
    input  logic [1:0]  s_tuser,
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    // state[3:0], arm_cmd[7:4], arm_move_ms[17:8], gripper_cmd[19:18],
    // drive_cmd[21:20], nav_cmd[23:22], goal_x[39:24], goal_y[55:40],
    // goal_heading_deg[63:56]
    output logic [63:0] m_tdata,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_data
);
    import pmms_pkg::*;

    cfg_t                 cfg;
    item_t                s_item;
    item_t                in_reg;
    logic                 in_valid_reg;
    result_t              out_reg;
    logic                 out_valid_reg;
    ctrl_t                ctrl_reg;
    ctrl_t                ctrl_next;
    logic [TIME_BITS-1:0] start_ms_reg;
    logic [TIME_BITS-1:0] start_ms_next;
    result_t              step_res;
    logic                 out_free;
    logic                 step_fire;

    // configuration registers
    assign cfg_ready = 1'b1;

    pmms_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (cfg_valid && cfg_ready),
        .wr_addr (cfg_addr),
        .wr_data (cfg_data),
        .cfg     (cfg)
    );

    // unpack the input item
    assign s_item.mode         = s_tuser;
    assign s_item.time_ms      = s_tdata[31:0];
    assign s_item.target_state = s_tdata[35:32];
    assign s_item.estop        = s_tdata[36];
    assign s_item.yield_req    = s_tdata[37];
    assign s_item.nav_arrived  = s_tdata[38];
    assign s_item.rfid_seen    = s_tdata[39];
    assign s_item.dock_clear   = s_tdata[40];

    // pipeline flow control
    assign out_free  = !out_valid_reg || m_tready;
    assign step_fire = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_reg <= s_item;
        end
    end

    // sequencer step
    pmms_step #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .item          (in_reg),
        .cfg           (cfg),
        .ctrl          (ctrl_reg),
        .start_ms      (start_ms_reg),
        .ctrl_next     (ctrl_next),
        .start_ms_next (start_ms_next),
        .res           (step_res)
    );

    // sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg.mission_state      <= S_IDLE;
            ctrl_reg.state_before_yield <= S_IDLE;
            ctrl_reg.sub_step           <= SUB_POSE;
            start_ms_reg                <= '0;
        end else if (step_fire) begin
            ctrl_reg     <= ctrl_next;
            start_ms_reg <= start_ms_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_fire) begin
            out_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.goal_heading_deg, out_reg.goal_y, out_reg.goal_x,
                       out_reg.nav_cmd, out_reg.drive_cmd, out_reg.gripper_cmd,
                       out_reg.arm_move_ms, out_reg.arm_cmd, out_reg.state};

    // reported state matches the sequencer state that the step produced
    assert property (@(posedge aclk) disable iff (!aresetn)
        step_fire |=> (m_tdata[3:0] == ctrl_reg.mission_state))
        else $error("result state differs from sequencer state");

    // a pose duration only comes with a pose command
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[17:8] != MOVE_NONE_MS)) |->
        ((m_tdata[7:4] != ARM_NONE) && (m_tdata[7:4] != ARM_STOP)))
        else $error("arm duration without a pose command");

    // sub-steps are only live in the timed states
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl_reg.sub_step != SUB_POSE) |->
        ((ctrl_reg.mission_state == S_PICK) || (ctrl_reg.mission_state == S_RELEASE) ||
         (ctrl_reg.mission_state == S_LIFT) || (ctrl_reg.mission_state == S_RETRACT)))
        else $error("sub-step set outside a timed state");

    // input back-pressure only when both registers are full and stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a full pipeline");

endmodule

// ===== rtl/core/pmms_cfg_regs.sv =====
// pmms_cfg_regs: configuration register file of the mission sequencer.
// Depends on pmms_pkg for cfg_t, register indexes and reset values.
module pmms_cfg_regs (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  logic [2:0]        wr_addr,
    input  logic [15:0]       wr_data,
    output pmms_pkg::cfg_t    cfg
);
    import pmms_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // write decode, indexes beyond the list are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_addr)
                CFG_PICK_X:      cfg_next.pick_x            = wr_data;
                CFG_PICK_Y:      cfg_next.pick_y            = wr_data;
                CFG_DROP_X:      cfg_next.drop_x            = wr_data;
                CFG_DROP_Y:      cfg_next.drop_y            = wr_data;
                CFG_VERIFY_TO:   cfg_next.verify_timeout_ms = wr_data;
                CFG_POSE_SETTLE: cfg_next.pose_settle_ms    = wr_data;
                CFG_GRIP_SETTLE: cfg_next.grip_settle_ms    = wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pick_x            <= PICK_X_RST;
            cfg_reg.pick_y            <= PICK_Y_RST;
            cfg_reg.drop_x            <= DROP_X_RST;
            cfg_reg.drop_y            <= DROP_Y_RST;
            cfg_reg.verify_timeout_ms <= VERIFY_TO_RST;
            cfg_reg.pose_settle_ms    <= POSE_SETTLE_RST;
            cfg_reg.grip_settle_ms    <= GRIP_SETTLE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/pmms_step.sv =====
// pmms_step: next-state and command logic for one item of the sequencer.
// Purely combinational; depends on pmms_pkg for codes and struct types.
module pmms_step #(
    parameter int TIME_BITS = pmms_pkg::TIME_BITS_DEFAULT
) (
    input  pmms_pkg::item_t         item,
    input  pmms_pkg::cfg_t          cfg,
    input  pmms_pkg::ctrl_t         ctrl,
    input  logic [TIME_BITS-1:0]    start_ms,
    output pmms_pkg::ctrl_t         ctrl_next,
    output logic [TIME_BITS-1:0]    start_ms_next,
    output pmms_pkg::result_t       res
);
    import pmms_pkg::*;

    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] start_eff;
    logic [TIME_BITS-1:0] elapsed;
    logic [3:0]           run_state;
    logic [1:0]           run_sub;
    logic                 restore;
    logic                 run_tick;
    logic                 past_verify;
    logic                 past_pose;
    logic                 past_grip;
    logic                 is_pick;

    // time base, truncated or widened to the stamp width
    assign now = TIME_BITS'(item.time_ms);

    // a plain tick runs the state machine; leaving yield restores first
    assign run_tick  = (item.mode == MODE_TICK) && !item.estop && !item.yield_req;
    assign restore   = run_tick && (ctrl.mission_state == S_YIELD);
    assign run_state = restore ? ctrl.state_before_yield : ctrl.mission_state;
    assign run_sub   = restore ? SUB_POSE : ctrl.sub_step;
    assign start_eff = restore ? now : start_ms;

    // wrapping elapsed time and strict timeouts
    assign elapsed     = now - start_eff;
    assign past_verify = elapsed > TIME_BITS'(cfg.verify_timeout_ms);
    assign past_pose   = elapsed > TIME_BITS'(cfg.pose_settle_ms);
    assign past_grip   = elapsed > TIME_BITS'(cfg.grip_settle_ms);

    assign is_pick = (run_state == S_PICK);

    always_comb begin
        res           = '0;
        ctrl_next     = ctrl;
        start_ms_next = start_ms;

        unique case (item.mode)
            MODE_START: begin
                res.arm_cmd          = ARM_HOME;
                res.arm_move_ms      = MOVE_SHORT_MS;
                res.nav_cmd          = NAV_GOAL;
                res.goal_x           = cfg.pick_x;
                res.goal_y           = cfg.pick_y;
                res.goal_heading_deg = HEADING_PICK;
                ctrl_next.mission_state = S_NAVPICK;
                ctrl_next.sub_step      = SUB_POSE;
                start_ms_next           = now;
            end
            MODE_ABORT: begin
                res.nav_cmd   = NAV_STOP;
                res.drive_cmd = DRIVE_STOP;
                res.arm_cmd   = ARM_STOP;
                ctrl_next.mission_state = S_IDLE;
                ctrl_next.sub_step      = SUB_POSE;
                start_ms_next           = now;
            end
            MODE_SET: begin
                // the unused code above fault is taken as fault
                ctrl_next.mission_state = (item.target_state > S_FAULT) ? S_FAULT
                                                                      : item.target_state;
                ctrl_next.sub_step      = SUB_POSE;
                start_ms_next           = now;
            end
            default: begin
                priority if (item.estop) begin
                    // latch estop, no command
                    if (ctrl.mission_state != S_ESTOP) begin
                        ctrl_next.mission_state = S_ESTOP;
                        ctrl_next.sub_step      = SUB_POSE;
                        start_ms_next           = now;
                    end
                end else if (item.yield_req) begin
                    // pick and release only pause
                    if (ctrl.mission_state != S_YIELD && ctrl.mission_state != S_PICK &&
                        ctrl.mission_state != S_RELEASE) begin
                        ctrl_next.state_before_yield = ctrl.mission_state;
                        ctrl_next.mission_state      = S_YIELD;
                        ctrl_next.sub_step           = SUB_POSE;
                        start_ms_next                = now;
                    end
                end else begin
                    ctrl_next.mission_state = run_state;
                    ctrl_next.sub_step      = run_sub;
                    start_ms_next           = start_eff;

                    // mission state machine
                    unique case (run_state)
                        S_IDLE: begin
                            res.drive_cmd = DRIVE_STOP;
                        end
                        S_NAVPICK, S_NAVDROP: begin
                            res.nav_cmd = NAV_STEP;
                            if (item.nav_arrived) begin
                                ctrl_next.mission_state = (run_state == S_NAVPICK) ?
                                                          S_VERIFY : S_POSITION;
                                ctrl_next.sub_step      = SUB_POSE;
                                start_ms_next           = now;
                            end
                        end
                        S_VERIFY: begin
                            res.drive_cmd = DRIVE_STOP;
                            if (item.rfid_seen || past_verify) begin
                                res.arm_cmd     = ARM_APPROACH;
                                res.arm_move_ms = MOVE_LONG_MS;
                                ctrl_next.mission_state = S_DOCK;
                                ctrl_next.sub_step      = SUB_POSE;
                                start_ms_next           = now;
                            end
                        end
                        S_DOCK: begin
                            if (!item.dock_clear) begin
                                res.drive_cmd = DRIVE_CREEP;
                            end else begin
                                res.drive_cmd = DRIVE_STOP;
                                ctrl_next.mission_state = S_PICK;
                                ctrl_next.sub_step      = SUB_POSE;
                                start_ms_next           = now;
                            end
                        end
                        S_PICK, S_RELEASE: begin
                            res.drive_cmd = DRIVE_STOP;
                            if (run_sub == SUB_POSE) begin
                                res.arm_cmd        = is_pick ? ARM_PICK : ARM_DROP;
                                res.arm_move_ms    = MOVE_MID_MS;
                                ctrl_next.sub_step = SUB_SETTLE;
                                start_ms_next      = now;
                            end else if (run_sub == SUB_SETTLE && past_pose) begin
                                res.gripper_cmd    = is_pick ? GRIP_CLOSE : GRIP_OPEN;
                                ctrl_next.sub_step = SUB_GRIP;
                                start_ms_next      = now;
                            end else if (run_sub == SUB_GRIP && past_grip) begin
                                ctrl_next.mission_state = is_pick ? S_LIFT : S_RETRACT;
                                ctrl_next.sub_step      = SUB_POSE;
                                start_ms_next           = now;
                            end
                        end
                        S_LIFT: begin
                            if (run_sub == SUB_POSE) begin
                                res.arm_cmd        = ARM_LIFT;
                                res.arm_move_ms    = MOVE_MID_MS;
                                ctrl_next.sub_step = SUB_SETTLE;
                                start_ms_next      = now;
                            end else if (run_sub == SUB_SETTLE && past_pose) begin
                                res.arm_cmd          = ARM_TRANSPORT;
                                res.arm_move_ms      = MOVE_SHORT_MS;
                                res.nav_cmd          = NAV_GOAL;
                                res.goal_x           = cfg.drop_x;
                                res.goal_y           = cfg.drop_y;
                                res.goal_heading_deg = HEADING_DROP;
                                ctrl_next.mission_state = S_NAVDROP;
                                ctrl_next.sub_step      = SUB_POSE;
                                start_ms_next           = now;
                            end
                        end
                        S_POSITION: begin
                            res.drive_cmd   = DRIVE_STOP;
                            res.arm_cmd     = ARM_APPROACH;
                            res.arm_move_ms = MOVE_MID_MS;
                            if (past_pose) begin
                                ctrl_next.mission_state = S_RELEASE;
                                ctrl_next.sub_step      = SUB_POSE;
                                start_ms_next           = now;
                            end
                        end
                        S_RETRACT: begin
                            if (run_sub == SUB_POSE) begin
                                res.arm_cmd        = ARM_RETRACT;
                                res.arm_move_ms    = MOVE_MID_MS;
                                ctrl_next.sub_step = SUB_SETTLE;
                                start_ms_next      = now;
                            end else if (run_sub == SUB_SETTLE && past_pose) begin
                                res.arm_cmd     = ARM_HOME;
                                res.arm_move_ms = MOVE_SHORT_MS;
                                ctrl_next.mission_state = S_IDLE;
                                ctrl_next.sub_step      = SUB_POSE;
                                start_ms_next           = now;
                            end
                        end
                        default: begin
                            // safestop, estop, commloss and fault hold the drive
                            res.drive_cmd = DRIVE_STOP;
                        end
                    endcase
                end
            end
        endcase

        res.state = ctrl_next.mission_state;
    end

endmodule
